// ===== sv/bms_pkg.sv =====
package bms_pkg;

   // Source store geometry: a square array with a power-of-two row stride.
   localparam int SRC_DIM     = 64;
   localparam int SRC_BITS    = $clog2(SRC_DIM);
   localparam int STORE_DEPTH = SRC_DIM * SRC_DIM;
   localparam int STORE_ABITS = $clog2(STORE_DEPTH);

   // Field widths.
   localparam int PIX_W   = 8;
   localparam int DST_W   = 8;
   localparam int CSR_W   = 8;
   localparam int CSR_IDX_W = 2;

   // Fixed-point layout: Q.16 coordinates and weights.
   localparam int FRAC_W  = 16;
   localparam int PROD_W  = DST_W + SRC_BITS;
   localparam int NUM_W   = PROD_W + FRAC_W;
   localparam int QUO_W   = SRC_BITS + FRAC_W;
   localparam int ROW_W   = PIX_W + FRAC_W + 1;
   localparam int ACC_W   = ROW_W + FRAC_W + 1;

   // Blend threshold, 128 in Q.32.
   localparam logic signed [ACC_W-1:0] BLEND_THRESH = ACC_W'(128) << (2 * FRAC_W);

   localparam logic [PIX_W-1:0] PIX_ON  = 8'd255;
   localparam logic [PIX_W-1:0] PIX_OFF = 8'd0;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_DST_WIDTH  = 2'd2,
      CSR_DST_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic [14:0] {
      ST_CLEAR   = 15'h0001,
      ST_IDLE    = 15'h0002,
      ST_UNS_RD  = 15'h0004,
      ST_UNS_CAP = 15'h0008,
      ST_DIV_X   = 15'h0010,
      ST_DIV_Y   = 15'h0020,
      ST_RD0     = 15'h0040,
      ST_RD1     = 15'h0080,
      ST_RD2     = 15'h0100,
      ST_RD3     = 15'h0200,
      ST_ROW_T   = 15'h0400,
      ST_ROW_B   = 15'h0800,
      ST_COL     = 15'h1000,
      ST_DONE    = 15'h2000,
      ST_SPARE   = 15'h4000
   } bms_state_type;

   // Access to the source store from the sequencer.
   typedef struct packed {
      logic                we;
      logic [SRC_BITS-1:0] wx;
      logic [SRC_BITS-1:0] wy;
      logic [PIX_W-1:0]    wdata;
      logic [SRC_BITS-1:0] rx;
      logic [SRC_BITS-1:0] ry;
   } bms_store_cmd_type;

endpackage

// ===== sv/bms_req_if.sv =====
interface bms_req_if import bms_pkg::*; ();

   logic             valid;
   logic             ready;
   logic             operation;
   logic [DST_W-1:0] coord_x;
   logic [DST_W-1:0] coord_y;
   logic [PIX_W-1:0] pixel_in;

   modport source (output valid, operation, coord_x, coord_y, pixel_in, input ready);
   modport sink   (input valid, operation, coord_x, coord_y, pixel_in, output ready);

endinterface

// ===== sv/bms_rsp_if.sv =====
interface bms_rsp_if import bms_pkg::*; ();

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_out;

   modport source (output valid, pixel_out, input ready);
   modport sink   (input valid, pixel_out, output ready);

endinterface

// ===== sv/bilinear_mask_scaler.sv =====
// Write beats leave the sequencer idle, so the block stays ready for the next beat.
// An unscaled query reads the store once; a scaled query runs two 30-step
// divisions in the shared divider, four reads through the store's single read
// port and three passes through one multiplier.
// No new beat is taken while a query is in progress; it is ready again when the result appears.
// Reset is synchronous; afterwards the input stays not ready
// while the store is cleared.
module bilinear_mask_scaler import bms_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   bms_req_if.sink              req,
   bms_rsp_if.source            rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   bms_state_type state_ff, state_in;

   logic [SRC_BITS-1:0] src_w_ff, src_h_ff;
   logic [DST_W-1:0]    dst_w_ff, dst_h_ff;
   logic [SRC_BITS-1:0] pw, ph;

   logic [DST_W-1:0]    cx_ff, cy_ff;
   logic [SRC_BITS-1:0] lx_ff, hx_ff, ly_ff, hy_ff;
   logic [FRAC_W-1:0]   fx_ff, fy_ff;
   logic [PIX_W-1:0]    p00_ff, p01_ff, p10_ff, p11_ff;
   logic signed [ROW_W-1:0] top_ff, bot_ff;
   logic [PIX_W-1:0]    result_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]    rsp_pixel_ff;

   logic req_fire, out_free;
   logic wr_ok, q_in_range, unscaled;

   logic              div_start, div_done;
   logic [NUM_W-1:0]  div_numer;
   logic [DST_W-1:0]  div_denom;
   logic [QUO_W-1:0]  div_quot;
   logic [DST_W-1:0]  div_coord;
   logic [SRC_BITS-1:0] div_pad;
   logic [PROD_W-1:0] div_prod;
   logic [SRC_BITS-1:0] quo_lo, quo_hi, quo_pad;

   bms_store_cmd_type   store_cmd;
   logic [PIX_W-1:0]    rd_data;
   logic                clr_busy;

   logic [PIX_W-1:0]        row_l, row_r;
   logic signed [PIX_W:0]   row_diff;
   logic signed [ROW_W-1:0] mac_a;
   logic [FRAC_W-1:0]       mac_f;
   logic signed [FRAC_W:0]  mac_fs;
   logic signed [ACC_W-1:0] mac_base, mac_sum;
   logic                    blend_hit;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= SRC_BITS'(1);
         src_h_ff <= SRC_BITS'(1);
         dst_w_ff <= DST_W'(1);
         dst_h_ff <= DST_W'(1);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SRC_WIDTH:  src_w_ff <= csr_wdata[SRC_BITS-1:0];
            CSR_SRC_HEIGHT: src_h_ff <= csr_wdata[SRC_BITS-1:0];
            CSR_DST_WIDTH:  dst_w_ff <= csr_wdata[DST_W-1:0];
            CSR_DST_HEIGHT: dst_h_ff <= csr_wdata[DST_W-1:0];
         endcase
      end
   end

   // Padded source size is always odd.
   assign pw = src_w_ff | SRC_BITS'(1);
   assign ph = src_h_ff | SRC_BITS'(1);

   assign req.ready  = (state_ff == ST_IDLE);
   assign req_fire   = req.valid && req.ready;
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign wr_ok      = (req.coord_x < {2'b00, src_w_ff}) && (req.coord_y < {2'b00, src_h_ff});
   assign q_in_range = (req.coord_x < dst_w_ff) && (req.coord_y < dst_h_ff);
   assign unscaled   = (dst_w_ff == {2'b00, pw}) && (dst_h_ff == {2'b00, ph});

   // Divider feed: x axis starts on acceptance, y axis when x has finished.
   assign div_coord = (state_ff == ST_IDLE) ? req.coord_x : cy_ff;
   assign div_pad   = (state_ff == ST_IDLE) ? pw : ph;
   assign div_denom = (state_ff == ST_IDLE) ? dst_w_ff : dst_h_ff;
   assign div_prod  = PROD_W'(div_coord) * PROD_W'(div_pad);
   assign div_numer = {div_prod, {FRAC_W{1'b0}}};
   assign div_start = (req_fire && (req.operation == OP_QUERY) && q_in_range && !unscaled)
                   || ((state_ff == ST_DIV_X) && div_done);

   bms_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Neighbour columns or rows; the upper one is clamped to the padded edge
   // of the axis whose quotient has just finished.
   assign quo_pad = (state_ff == ST_DIV_X) ? pw : ph;
   assign quo_lo  = div_quot[QUO_W-1:FRAC_W];
   assign quo_hi  = (quo_lo == quo_pad - SRC_BITS'(1)) ? quo_lo : quo_lo + SRC_BITS'(1);

   // Store access: writes come straight from the accepted beat.
   always_comb begin
      store_cmd.we    = req_fire && (req.operation == OP_WRITE) && wr_ok;
      store_cmd.wx    = req.coord_x[SRC_BITS-1:0];
      store_cmd.wy    = req.coord_y[SRC_BITS-1:0];
      store_cmd.wdata = req.pixel_in[PIX_W-1] ? req.pixel_in : PIX_OFF;
      store_cmd.rx    = lx_ff;
      store_cmd.ry    = ly_ff;
      priority if (state_ff == ST_UNS_RD) begin
         store_cmd.rx = cx_ff[SRC_BITS-1:0];
         store_cmd.ry = cy_ff[SRC_BITS-1:0];
      end else if (state_ff == ST_RD1) begin
         store_cmd.rx = hx_ff;
      end else if (state_ff == ST_RD2) begin
         store_cmd.ry = hy_ff;
      end else if (state_ff == ST_RD3) begin
         store_cmd.rx = hx_ff;
         store_cmd.ry = hy_ff;
      end else begin
         store_cmd.rx = lx_ff;
      end
   end

   bms_store u_store (
      .clock    (clock),
      .reset    (reset),
      .cmd      (store_cmd),
      .src_w    (src_w_ff),
      .src_h    (src_h_ff),
      .rd_data  (rd_data),
      .clr_busy (clr_busy)
   );

   // Shared multiply-add: two row blends, then the column blend.
   assign row_l    = (state_ff == ST_ROW_B) ? p10_ff : p00_ff;
   assign row_r    = (state_ff == ST_ROW_B) ? p11_ff : p01_ff;
   assign row_diff = $signed({1'b0, row_r}) - $signed({1'b0, row_l});

   always_comb begin
      if (state_ff == ST_COL) begin
         mac_a    = bot_ff - top_ff;
         mac_f    = fy_ff;
         mac_base = {{(ACC_W-ROW_W-FRAC_W){top_ff[ROW_W-1]}}, top_ff, {FRAC_W{1'b0}}};
      end else begin
         mac_a    = ROW_W'(row_diff);
         mac_f    = fx_ff;
         mac_base = $signed({{(ACC_W-PIX_W-FRAC_W){1'b0}}, row_l, {FRAC_W{1'b0}}});
      end
   end

   assign mac_fs    = $signed({1'b0, mac_f});
   assign mac_sum   = mac_base + ACC_W'(mac_a) * ACC_W'(mac_fs);
   assign blend_hit = mac_sum > BLEND_THRESH;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:   if (!clr_busy) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_fire && (req.operation == OP_QUERY) && q_in_range) begin
               state_in = unscaled ? ST_UNS_RD : ST_DIV_X;
            end
         end
         ST_UNS_RD:  state_in = ST_UNS_CAP;
         ST_UNS_CAP: state_in = ST_DONE;
         ST_DIV_X:   if (div_done) state_in = ST_DIV_Y;
         ST_DIV_Y:   if (div_done) state_in = ST_RD0;
         ST_RD0:     state_in = ST_RD1;
         ST_RD1:     state_in = ST_RD2;
         ST_RD2:     state_in = ST_RD3;
         ST_RD3:     state_in = ST_ROW_T;
         ST_ROW_T:   state_in = ST_ROW_B;
         ST_ROW_B:   state_in = ST_COL;
         ST_COL:     state_in = ST_DONE;
         ST_DONE:    if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Output register: loaded when the previous beat has gone.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cx_ff <= req.coord_x;
         cy_ff <= req.coord_y;
      end
      if ((state_ff == ST_DIV_X) && div_done) begin
         lx_ff <= quo_lo;
         hx_ff <= quo_hi;
         fx_ff <= div_quot[FRAC_W-1:0];
      end
      if ((state_ff == ST_DIV_Y) && div_done) begin
         ly_ff <= quo_lo;
         hy_ff <= quo_hi;
         fy_ff <= div_quot[FRAC_W-1:0];
      end
      if (state_ff == ST_RD1)   p00_ff <= rd_data;
      if (state_ff == ST_RD2)   p01_ff <= rd_data;
      if (state_ff == ST_RD3)   p10_ff <= rd_data;
      if (state_ff == ST_ROW_T) begin
         p11_ff <= rd_data;
         top_ff <= mac_sum[ROW_W-1:0];
      end
      if (state_ff == ST_ROW_B) bot_ff <= mac_sum[ROW_W-1:0];
      if (state_ff == ST_UNS_CAP) result_ff <= rd_data;
      if (state_ff == ST_COL)   result_ff <= blend_hit ? PIX_ON : PIX_OFF;
      if ((state_ff == ST_DONE) && out_free) rsp_pixel_ff <= result_ff;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.pixel_out = rsp_pixel_ff;

   // No beat is taken while the store is still being cleared.
   a_ready_after_clear: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !clr_busy)
      else $error("input ready during store clearing");

   // A finished result reaches the output register and the sequencer returns to idle.
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && out_free) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("finished result not delivered to output register");

   // The divider is only started for the x axis or, after it, the y axis.
   a_div_start_src: assert property (@(posedge clock) disable iff (reset)
      div_start |-> ((state_ff == ST_IDLE) || (state_ff == ST_DIV_X)))
      else $error("divider started from an unexpected state");

   // Source row neighbours always lie inside the padded source.
   a_rows_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIV_Y) && div_done) |=> ((hy_ff < ph) && (ly_ff <= hy_ff)))
      else $error("source row neighbours out of range");

endmodule

// ===== sv/bms_divider.sv =====
module bms_divider import bms_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DST_W-1:0] denom,
   output logic             done,
   output logic [QUO_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] shreg_ff, shreg_in;
   logic [DST_W-1:0] rem_ff, rem_in;
   logic [DST_W-1:0] denom_ff, denom_in;
   logic [DST_W:0]   trial;
   logic [DST_W:0]   trial_sub;
   logic             fits;

   // One restoring step per cycle: the numerator shifts out at the top
   // while quotient bits shift in at the bottom.
   assign trial     = {rem_ff, shreg_ff[NUM_W-1]};
   assign fits      = trial >= {1'b0, denom_ff};
   assign trial_sub = trial - {1'b0, denom_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shreg_in = shreg_ff;
      rem_in   = rem_ff;
      denom_in = denom_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shreg_in = numer;
         rem_in   = '0;
         denom_in = denom;
      end else if (busy_ff) begin
         shreg_in = {shreg_ff[NUM_W-2:0], fits};
         rem_in   = fits ? trial_sub[DST_W-1:0] : trial[DST_W-1:0];
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shreg_ff <= shreg_in;
      rem_ff   <= rem_in;
      denom_ff <= denom_in;
   end

   assign done = done_ff;
   assign quot = shreg_ff[QUO_W-1:0];

   // A new division is only started once the previous one has finished.
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

endmodule

// ===== sv/bms_store.sv =====
module bms_store import bms_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  bms_store_cmd_type   cmd,
   input  logic [SRC_BITS-1:0] src_w,
   input  logic [SRC_BITS-1:0] src_h,
   output logic [PIX_W-1:0]    rd_data,
   output logic                clr_busy
);

   logic [PIX_W-1:0]       mem [STORE_DEPTH];
   logic [PIX_W-1:0]       q_ff;
   logic                   rd_ok_ff;
   logic                   clr_busy_ff, clr_busy_in;
   logic [STORE_ABITS-1:0] clr_addr_ff, clr_addr_in;

   // Clearing pass after reset, one entry a cycle.
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == STORE_ABITS'(STORE_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Single write port, shared between the clearing pass and pixel loads.
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (cmd.we) begin
         mem[{cmd.wy, cmd.wx}] <= cmd.wdata;
      end
   end

   // Registered read; columns and rows beyond the unpadded size read as zero.
   always_ff @(posedge clock) begin
      q_ff     <= mem[{cmd.ry, cmd.rx}];
      rd_ok_ff <= (cmd.rx < src_w) && (cmd.ry < src_h);
   end

   assign rd_data  = rd_ok_ff ? q_ff : '0;
   assign clr_busy = clr_busy_ff;

endmodule
